>>> hw/rtl/cfcd_pkg.sv
// Package: shared constants and types of the CAN frame class dispatcher.
package cfcd_pkg;

	localparam int QUEUE_DEPTH    = 32;
	localparam int REQUEST_BUDGET = 2;
	localparam int COMMAND_BUDGET = 6;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int RBUD_W = $clog2(REQUEST_BUDGET + 1);
	localparam int CBUD_W = $clog2(COMMAND_BUDGET + 1);
	localparam int META_W = 28;
	localparam int ENTRY_W = 64 + META_W;

	localparam logic [7:0] ACK_BYTE = 8'h43;

	// register indexes
	localparam logic [1:0] REG_DEVICE_ID  = 2'd0;
	localparam logic [1:0] REG_CLASS_REG  = 2'd1;
	localparam logic [1:0] REG_CLASS_REQ  = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_REQUEST = 3'd0;
	localparam logic [2:0] KIND_COMMAND = 3'd1;
	localparam logic [2:0] KIND_ACK     = 3'd2;
	localparam logic [2:0] KIND_TAKEN   = 3'd3;
	localparam logic [2:0] KIND_REFUSED = 3'd4;

	// queue selectors (one memory, three regions)
	localparam logic [1:0] Q_INGRESS = 2'd0;
	localparam logic [1:0] Q_REQUEST = 2'd1;
	localparam logic [1:0] Q_COMMAND = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  class_id;
		logic [19:0] reply_id;
		logic [3:0]  out_length;
		logic [63:0] out_data;
		logic        last;
	} result_t;

	typedef struct packed {
		logic               we;
		logic [1:0]         wq;
		logic [PTR_W-1:0]   waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [1:0]         rq;
		logic [PTR_W-1:0]   raddr;
	} mem_req_t;

endpackage

>>> hw/rtl/cfcd_if.sv
// Interfaces: valid/ready stream channels and the configuration write channel.
interface cfcd_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [28:0] frame_id;
	logic [3:0]  data_length;
	logic [63:0] frame_data;
	modport source (output valid, command, frame_id, data_length, frame_data, input ready);
	modport sink (input valid, command, frame_id, data_length, frame_data, output ready);
endinterface

interface cfcd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [3:0]  class_id;
	logic [19:0] reply_id;
	logic [3:0]  out_length;
	logic [63:0] out_data;
	logic        last;
	modport source (output valid, kind, class_id, reply_id, out_length, out_data, last,
		input ready);
	modport sink (input valid, kind, class_id, reply_id, out_length, out_data, last,
		output ready);
endinterface

interface cfcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/can_frame_class_dispatcher_top.sv
// Top level: CAN frame class dispatcher with config registers, sequencer and queue memory.
// Usage:
//   in_ch  carries transactions: command 0 is a received frame, command 1 an execute tick.
//   out_ch delivers result transactions; last marks the final result of an input.
//   cfg_ch writes device_id (0), class_registered (1), class_is_request (2) while idle.
// A frame is filtered on ID bits 28:24 and gives one result (taken or refused) in the
// cycle after acceptance; a filtered-out frame gives none.
// A tick sorts the ingress ring entry by entry (memory read, then write back) until it
// is empty or a destination ring is full, then dispatches up to 2 requests and 6
// commands, each a memory read then a result, plus an ack per registered command
// with a nonzero reply id and one closing result. One dispatch result is held back
// until the next one shows whether it is the last. Results sit in one output register;
// a stalled receiver holds the sequencer before its next memory read, ack or closing
// result. in_ch.ready is low while a tick is in progress or a result waits.
// Reset clears all ring pointers and counts and the registers; the queue memory needs
// no clearing since every entry is written before it is read.
module can_frame_class_dispatcher_top (
	input  logic       clk,
	input  logic       arst_n,
	cfcd_in_if.sink    in_ch,
	cfcd_out_if.source out_ch,
	cfcd_cfg_if.sink   cfg_ch
);
	import cfcd_pkg::*;

	logic [4:0]  device_id_q;
	logic [15:0] class_registered_q;
	logic [15:0] class_is_request_q;
	logic        res_valid;
	result_t     res;
	mem_req_t    mreq;
	logic [ENTRY_W-1:0] rdata;

	assign cfg_ch.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= '0;
			class_registered_q <= '0;
			class_is_request_q <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_DEVICE_ID: device_id_q <= cfg_ch.data[4:0];
				REG_CLASS_REG: class_registered_q <= cfg_ch.data[15:0];
				REG_CLASS_REQ: class_is_request_q <= cfg_ch.data[15:0];
				default: ;
			endcase
		end
	end

	cfcd_ctrl u_ctrl (
		.clk, .arst_n, .in_ch,
		.out_busy(!out_ch.ready),
		.res_valid, .res,
		.device_id(device_id_q),
		.class_registered(class_registered_q),
		.class_is_request(class_is_request_q),
		.mreq, .rdata
	);

	cfcd_queue_mem u_mem (.clk, .req(mreq), .rdata);

	assign out_ch.valid = res_valid;
	assign out_ch.kind = res.kind;
	assign out_ch.class_id = res.class_id;
	assign out_ch.reply_id = res.reply_id;
	assign out_ch.out_length = res.out_length;
	assign out_ch.out_data = res.out_data;
	assign out_ch.last = res.last;
endmodule

>>> hw/rtl/cfcd_queue_mem.sv
// Queue storage: one synchronous memory holding the ingress, request and command rings.
module cfcd_queue_mem (
	input  logic                     clk,
	input  cfcd_pkg::mem_req_t       req,
	output logic [cfcd_pkg::ENTRY_W-1:0] rdata
);
	import cfcd_pkg::*;

	logic [ENTRY_W-1:0] mem [3*QUEUE_DEPTH];

	// write and registered read, one port each
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[{req.wq, req.waddr}] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[{req.rq, req.raddr}];
		end
	end
endmodule

>>> hw/rtl/cfcd_ctrl.sv
// Sequencer: frame intake, tick sorting and dispatch over the queue memory.
module cfcd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	cfcd_in_if.sink                       in_ch,
	input  logic                          out_busy,
	output logic                          res_valid,
	output cfcd_pkg::result_t             res,
	input  logic [4:0]                    device_id,
	input  logic [15:0]                   class_registered,
	input  logic [15:0]                   class_is_request,
	output cfcd_pkg::mem_req_t            mreq,
	input  logic [cfcd_pkg::ENTRY_W-1:0]  rdata
);
	import cfcd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SORT_RD, ST_SORT_WT, ST_REQ_RD, ST_REQ_WT, ST_CMD_RD, ST_CMD_WT, ST_ACK,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic [PTR_W-1:0] ihead_q, rhead_q, chead_q;
	logic [CNT_W-1:0] icnt_q, rcnt_q, ccnt_q;
	logic [RBUD_W-1:0] rbud_q;
	logic [CBUD_W-1:0] cbud_q;
	result_t hold_q;
	logic hold_v_q;
	logic [19:0] ack_id_q;
	logic [3:0]  cls;
	logic [META_W-1:0] meta;
	logic [63:0] masked;
	logic [3:0]  len;
	logic [63:0] pl;
	logic        reg_ok, to_req, dst_full, rd_more, cd_more, cd_left, cmd_ack;

	// frame intake: saturate length, clear slack bytes
	always_comb begin
		len = (in_ch.data_length > 4'd8) ? 4'd8 : in_ch.data_length;
		masked = in_ch.frame_data;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) >= len) masked[b*8 +: 8] = 8'h00;
		end
	end

	assign meta   = rdata[ENTRY_W-1 -: META_W];
	assign pl     = rdata[63:0];
	assign cls    = meta[23:20];
	assign reg_ok = class_registered[cls];
	assign to_req = class_is_request[cls];
	assign dst_full = to_req ? (rcnt_q == CNT_W'(QUEUE_DEPTH))
		: (ccnt_q == CNT_W'(QUEUE_DEPTH));
	assign cmd_ack = reg_ok && (meta[19:0] != 20'd0);

	assign in_ch.ready = (state_q == ST_IDLE) && !res_valid;

	// next-read conditions after popping the current entry
	assign rd_more = (rbud_q > RBUD_W'(1)) && (rcnt_q > CNT_W'(1));
	assign cd_more = (cbud_q > CBUD_W'(1)) && (ccnt_q > CNT_W'(1));
	// in the ack slot the command is already popped
	assign cd_left = (cbud_q != '0) && (ccnt_q != '0);

	// memory requests
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_IDLE: begin
				mreq.we = in_ch.valid && in_ch.ready && !in_ch.command
					&& (in_ch.frame_id[28:24] == device_id) && (icnt_q != CNT_W'(QUEUE_DEPTH));
				mreq.wq = Q_INGRESS;
				mreq.waddr = ihead_q + icnt_q[PTR_W-1:0];
				mreq.wdata = {len, in_ch.frame_id[23:0], masked};
			end
			ST_SORT_RD: begin
				mreq.re = 1'b1;
				mreq.rq = Q_INGRESS;
				mreq.raddr = ihead_q;
			end
			ST_SORT_WT: begin
				mreq.we = reg_ok && !dst_full;
				mreq.wq = to_req ? Q_REQUEST : Q_COMMAND;
				mreq.waddr = to_req ? rhead_q + rcnt_q[PTR_W-1:0] : chead_q + ccnt_q[PTR_W-1:0];
				mreq.wdata = rdata;
			end
			ST_REQ_RD: begin
				mreq.re = 1'b1;
				mreq.rq = Q_REQUEST;
				mreq.raddr = rhead_q;
			end
			ST_CMD_RD: begin
				mreq.re = 1'b1;
				mreq.rq = Q_COMMAND;
				mreq.raddr = chead_q;
			end
			default: ;
		endcase
	end

	// sequencer with registered result; one dispatch result is held back until
	// the next one (or the end of the tick) decides its last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ihead_q <= '0; rhead_q <= '0; chead_q <= '0;
			icnt_q <= '0; rcnt_q <= '0; ccnt_q <= '0;
			rbud_q <= '0; cbud_q <= '0;
			hold_q <= '0;
			hold_v_q <= 1'b0;
			res_valid <= 1'b0;
			ack_id_q <= '0;
		end else begin
			if (res_valid && !out_busy && state_q != ST_ACK && state_q != ST_FLUSH)
				res_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (in_ch.command) begin
							rbud_q <= RBUD_W'(REQUEST_BUDGET);
							cbud_q <= CBUD_W'(COMMAND_BUDGET);
							state_q <= ST_SORT_RD;
							if (icnt_q == '0) state_q <= ST_REQ_RD;
							if (icnt_q == '0 && rcnt_q == '0) state_q <= ST_CMD_RD;
							if (icnt_q == '0 && rcnt_q == '0 && ccnt_q == '0) state_q <= ST_IDLE;
						end else if (in_ch.frame_id[28:24] == device_id) begin
							res_valid <= 1'b1;
							res.kind <= (icnt_q == CNT_W'(QUEUE_DEPTH)) ? KIND_REFUSED : KIND_TAKEN;
							res.class_id <= in_ch.frame_id[23:20];
							res.reply_id <= in_ch.frame_id[19:0];
							res.out_length <= len;
							res.out_data <= masked;
							res.last <= 1'b1;
							if (icnt_q != CNT_W'(QUEUE_DEPTH)) icnt_q <= icnt_q + 1'b1;
						end
					end
				end
				ST_SORT_RD: state_q <= ST_SORT_WT;
				ST_SORT_WT: begin
					if (reg_ok && dst_full) begin
						state_q <= (rcnt_q != '0) ? ST_REQ_RD : (ccnt_q != '0) ? ST_CMD_RD : ST_IDLE;
					end else begin
						ihead_q <= ihead_q + 1'b1;
						icnt_q <= icnt_q - 1'b1;
						if (reg_ok && to_req) rcnt_q <= rcnt_q + 1'b1;
						if (reg_ok && !to_req) ccnt_q <= ccnt_q + 1'b1;
						if (icnt_q != CNT_W'(1)) state_q <= ST_SORT_RD;
						else if (rcnt_q != '0 || (reg_ok && to_req)) state_q <= ST_REQ_RD;
						else if (ccnt_q != '0 || reg_ok) state_q <= ST_CMD_RD;
						else state_q <= ST_IDLE;
					end
				end
				ST_REQ_RD: if (!res_valid || !out_busy) state_q <= ST_REQ_WT;
				ST_REQ_WT: begin
					rhead_q <= rhead_q + 1'b1;
					rcnt_q <= rcnt_q - 1'b1;
					rbud_q <= rbud_q - 1'b1;
					if (reg_ok) begin
						if (hold_v_q) begin
							res_valid <= 1'b1;
							res <= hold_q;
						end
						hold_v_q <= 1'b1;
						hold_q.kind <= KIND_REQUEST;
						hold_q.class_id <= cls;
						hold_q.reply_id <= meta[19:0];
						hold_q.out_length <= meta[27:24];
						hold_q.out_data <= pl;
						hold_q.last <= 1'b0;
					end
					if (rd_more) state_q <= ST_REQ_RD;
					else if (ccnt_q != '0) state_q <= ST_CMD_RD;
					else state_q <= (reg_ok || hold_v_q) ? ST_FLUSH : ST_IDLE;
				end
				ST_CMD_RD: if (!res_valid || !out_busy) state_q <= ST_CMD_WT;
				ST_CMD_WT: begin
					chead_q <= chead_q + 1'b1;
					ccnt_q <= ccnt_q - 1'b1;
					cbud_q <= cbud_q - 1'b1;
					ack_id_q <= meta[19:0];
					if (reg_ok) begin
						if (hold_v_q) begin
							res_valid <= 1'b1;
							res <= hold_q;
						end
						hold_v_q <= 1'b1;
						hold_q.kind <= KIND_COMMAND;
						hold_q.class_id <= cls;
						hold_q.reply_id <= meta[19:0];
						hold_q.out_length <= meta[27:24];
						hold_q.out_data <= pl;
						hold_q.last <= 1'b0;
					end
					if (cmd_ack) state_q <= ST_ACK;
					else if (cd_more) state_q <= ST_CMD_RD;
					else state_q <= (reg_ok || hold_v_q) ? ST_FLUSH : ST_IDLE;
				end
				ST_ACK: begin
					// the command before the ack is always held here
					if (!res_valid || !out_busy) begin
						res_valid <= 1'b1;
						res <= hold_q;
						hold_q.kind <= KIND_ACK;
						hold_q.class_id <= 4'd0;
						hold_q.reply_id <= ack_id_q;
						hold_q.out_length <= 4'd1;
						hold_q.out_data <= {56'd0, ACK_BYTE};
						hold_q.last <= 1'b0;
						state_q <= cd_left ? ST_CMD_RD : ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// final result of the tick
					if (!res_valid || !out_busy) begin
						res_valid <= 1'b1;
						res <= {hold_q[$bits(result_t)-1:1], 1'b1};
						hold_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_icnt: assert property (@(posedge clk) disable iff (!arst_n) icnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("ingress count overflow");
	a_rcnt: assert property (@(posedge clk) disable iff (!arst_n) rcnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("request count overflow");
	a_ccnt: assert property (@(posedge clk) disable iff (!arst_n) ccnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("command count overflow");
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACK) |-> (ack_id_q != 20'd0)) else $error("ack with zero reply id");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q) else $error("held result left at idle");
`endif
endmodule
